FILE: hw/rtl/twm_pkg.sv
// Shared types, widths and codes of the mesh point warp.
`default_nettype none
package twm_pkg;

	localparam int unsigned DEF_MAX_COLS = 8;
	localparam int unsigned DEF_MAX_ROWS = 8;

	localparam int unsigned COORD_W = 16;              // Q12.4 coordinate
	localparam int unsigned POINT_W = 2 * COORD_W;     // y in upper half, x in lower
	localparam int unsigned AREA_W  = 2 * (COORD_W + 1) + 1; // signed doubled area
	localparam int unsigned MAG_W   = AREA_W - 1;      // area magnitude
	localparam int unsigned NUM_W   = COORD_W + MAG_W; // weighted sum
	localparam int unsigned QUO_W   = COORD_W;         // Q12.4 quotient
	localparam int unsigned FRAC_W  = 4;
	localparam int unsigned OUT_W   = QUO_W - FRAC_W;
	localparam int unsigned IDX_W   = 7;
	localparam int unsigned CFG_W   = 4;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [1:0] CMD_LOAD_REF = 2'd0;
	localparam logic [1:0] CMD_LOAD_TGT = 2'd1;
	localparam logic [1:0] CMD_MAP      = 2'd2;
	localparam logic [1:0] CMD_NOP      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;

	// one stage of the quotient chain
	typedef struct packed {
		logic              valid;
		logic              axis;
		logic [NUM_W-1:0]  rem;
		logic [MAG_W-1:0]  den;
		logic [QUO_W-1:0]  quo;
	} div_stage_t;

endpackage
`default_nettype wire

FILE: hw/rtl/twm_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module twm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 81
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/twm_div_cell.sv
// One cell of the quotient chain: resolves a single quotient bit.
`default_nettype none
module twm_div_cell #(
	parameter int unsigned BIT = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire twm_pkg::div_stage_t din,
	output twm_pkg::div_stage_t      dout
);
	import twm_pkg::*;

	logic [NUM_W:0] shifted;
	logic [NUM_W:0] diff;
	logic           ge;

	assign shifted = (NUM_W + 1)'(din.den) << BIT;
	assign diff    = {1'b0, din.rem} - shifted;
	assign ge      = !diff[NUM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout.valid <= din.valid;
			dout.axis  <= din.axis;
			dout.den   <= din.den;
			dout.rem   <= ge ? diff[NUM_W-1:0] : din.rem;
			dout.quo   <= din.quo | (ge ? (QUO_W'(1) << BIT) : '0);
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/twm_divider.sv
// Pipelined restoring divider built as a chain of one-bit cells.
`default_nettype none
module twm_divider (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire twm_pkg::div_stage_t din,
	output twm_pkg::div_stage_t      dout
);
	import twm_pkg::*;

	div_stage_t st [QUO_W+1];

	assign st[0] = din;

	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		twm_div_cell #(.BIT(QUO_W - 1 - i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (st[i]),
			.dout   (st[i+1])
		);
	end

	assign dout = st[QUO_W];
endmodule
`default_nettype wire

FILE: hw/rtl/triangle_mesh_point_warp.sv
// Top level of the piecewise-linear mesh point warp.
// A load transfer writes one grid point. A map transfer walks the reference
// cells row by row and tests each triangle (three point reads through the
// reference RAM's single read port, three area products, one decision); a hit
// then takes three target reads, two 3-step weighted sums, and the 16-cell
// quotient chain shared by both axes. One item is worked at a time; the result
// sits in an output register so the next item can be taken while it waits.
`default_nettype none
module triangle_mesh_point_warp #(
	parameter int unsigned MAX_COLS = twm_pkg::DEF_MAX_COLS,
	parameter int unsigned MAX_ROWS = twm_pkg::DEF_MAX_ROWS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // point_index[6:0], coord_x[22:7], coord_y[38:23]
	input  wire logic [1:0]  s_axis_tuser,  // command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // mapped_x[11:0], mapped_y[23:12]
	output logic             m_axis_tuser,  // found
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [twm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [twm_pkg::CFG_W-1:0]     cfg_data
);
	import twm_pkg::*;

	localparam int unsigned DEPTH = (MAX_COLS + 1) * (MAX_ROWS + 1);
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(MAX_COLS + 1);
	localparam int unsigned RW    = $clog2(MAX_ROWS + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_FETCH  = 7'b0000010,
		S_CALC   = 7'b0000100,
		S_TFETCH = 7'b0001000,
		S_MAC    = 7'b0010000,
		S_DIV    = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [1:0] k_q;
	logic [CFG_W-1:0] grid_cols_q, grid_rows_q;
	logic [CW-1:0] col_q, cols_eff;
	logic [RW-1:0] row_q, rows_eff;
	logic [AW-1:0] base_q, stride, raddr;
	logic tri_q, axis_q;
	logic [COORD_W-1:0] px_q, py_q;
	logic [POINT_W-1:0] va_q, vb_q, vc_q, ta_q, tb_q, tc_q;
	logic [POINT_W-1:0] ref_rdata, tgt_rdata;
	logic signed [AREA_W-1:0] tot_q, aa_q, ab_q, ac;
	logic [MAG_W-1:0] wa_q, wb_q, wc_q, den_q;
	logic [NUM_W-1:0] acc_q;
	logic [OUT_W-1:0] mx_q, my_q;
	logic found_q;
	logic out_valid_q, out_found_q;
	logic [OUT_W-1:0] out_x_q, out_y_q;
	div_stage_t div_in, div_out;

	logic s_fire, idx_ok, ref_we, tgt_we;
	logic [1:0] cmd;

	assign cmd           = s_axis_tuser;
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign idx_ok        = (32'(s_axis_tdata[IDX_W-1:0]) < DEPTH);
	assign ref_we        = s_fire && (cmd == CMD_LOAD_REF) && idx_ok;
	assign tgt_we        = s_fire && (cmd == CMD_LOAD_TGT) && idx_ok;
	assign cfg_ready     = 1'b1;

	// effective grid size
	always_comb begin
		if (grid_cols_q == '0) cols_eff = CW'(1);
		else if (32'(grid_cols_q) > MAX_COLS) cols_eff = CW'(MAX_COLS);
		else cols_eff = CW'(grid_cols_q);
		if (grid_rows_q == '0) rows_eff = RW'(1);
		else if (32'(grid_rows_q) > MAX_ROWS) rows_eff = RW'(MAX_ROWS);
		else rows_eff = RW'(grid_rows_q);
	end

	assign stride = AW'(cols_eff) + AW'(1);

	// vertex address for the current read step
	always_comb begin
		unique case (k_q)
			2'd0:    raddr = tri_q ? base_q + AW'(1) : base_q;
			2'd1:    raddr = tri_q ? base_q + stride + AW'(1) : base_q + AW'(1);
			default: raddr = base_q + stride;
		endcase
	end

	twm_ram #(.WIDTH(POINT_W), .DEPTH(DEPTH)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (AW'(s_axis_tdata[IDX_W-1:0])),
		.wdata (s_axis_tdata[IDX_W +: POINT_W]),
		.raddr (raddr),
		.rdata (ref_rdata)
	);

	twm_ram #(.WIDTH(POINT_W), .DEPTH(DEPTH)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (AW'(s_axis_tdata[IDX_W-1:0])),
		.wdata (s_axis_tdata[IDX_W +: POINT_W]),
		.raddr (raddr),
		.rdata (tgt_rdata)
	);

	// area unit: f(u,v,w) = (ux-vx)(uy-wy) - (uy-vy)(ux-wx)
	logic [POINT_W-1:0] fu, fv, fw, pp;
	logic signed [COORD_W:0] d1, d2, d3, d4;
	logic signed [2*COORD_W+1:0] m1, m2;
	logic signed [AREA_W-1:0] f_val;

	assign pp = {py_q, px_q};

	always_comb begin
		unique case (k_q)
			2'd0:    begin fu = va_q; fv = vb_q; fw = vc_q; end
			2'd1:    begin fu = pp;   fv = vb_q; fw = vc_q; end
			default: begin fu = va_q; fv = pp;   fw = vc_q; end
		endcase
	end

	assign d1 = $signed({1'b0, fu[COORD_W-1:0]}) - $signed({1'b0, fv[COORD_W-1:0]});
	assign d2 = $signed({1'b0, fu[POINT_W-1:COORD_W]}) - $signed({1'b0, fw[POINT_W-1:COORD_W]});
	assign d3 = $signed({1'b0, fu[POINT_W-1:COORD_W]}) - $signed({1'b0, fv[POINT_W-1:COORD_W]});
	assign d4 = $signed({1'b0, fu[COORD_W-1:0]}) - $signed({1'b0, fw[COORD_W-1:0]});
	assign m1 = d1 * d2;
	assign m2 = d3 * d4;
	assign f_val = AREA_W'(m1) - AREA_W'(m2);

	// hit decision: a nonzero total, and every sub-area zero or of the sign of the total
	logic hit, last_cell, ok_a, ok_b, ok_c;
	assign ac   = tot_q - aa_q - ab_q;
	assign ok_a = (aa_q == '0) || (aa_q[AREA_W-1] == tot_q[AREA_W-1]);
	assign ok_b = (ab_q == '0) || (ab_q[AREA_W-1] == tot_q[AREA_W-1]);
	assign ok_c = (ac == '0) || (ac[AREA_W-1] == tot_q[AREA_W-1]);
	assign hit  = (tot_q != '0) && ok_a && ok_b && ok_c;
	assign last_cell = tri_q && (col_q == cols_eff - CW'(1)) && (row_q == rows_eff - RW'(1));

	function automatic logic [MAG_W-1:0] mag(input logic signed [AREA_W-1:0] v);
		logic signed [AREA_W-1:0] n;
		n = -v;
		return v[AREA_W-1] ? MAG_W'(n) : MAG_W'(v);
	endfunction

	// weighted sum, one product a cycle
	logic [POINT_W-1:0] tsel;
	logic [MAG_W-1:0] wsel;
	logic [COORD_W-1:0] csel;
	logic [NUM_W-1:0] prod;

	always_comb begin
		unique case (k_q)
			2'd0:    begin tsel = ta_q; wsel = wa_q; end
			2'd1:    begin tsel = tb_q; wsel = wb_q; end
			default: begin tsel = tc_q; wsel = wc_q; end
		endcase
	end
	assign csel = axis_q ? tsel[POINT_W-1:COORD_W] : tsel[COORD_W-1:0];
	assign prod = NUM_W'(csel) * NUM_W'(wsel);

	assign div_in.valid = (state_q == S_MAC) && (k_q == 2'd3);
	assign div_in.axis  = axis_q;
	assign div_in.rem   = acc_q;
	assign div_in.den   = den_q;
	assign div_in.quo   = '0;

	twm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (div_in),
		.dout   (div_out)
	);

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= 2'd0;
			grid_cols_q <= CFG_W'(4);
			grid_rows_q <= CFG_W'(4);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GRID_COLS) grid_cols_q <= cfg_data;
				else if (cfg_index == REG_GRID_ROWS) grid_rows_q <= cfg_data;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					k_q <= 2'd0;
					if (s_fire && (cmd == CMD_MAP)) state_q <= S_FETCH;
				end
				S_FETCH: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) state_q <= S_CALC;
				end
				S_CALC: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						if (hit) state_q <= S_TFETCH;
						else if (last_cell) state_q <= S_DONE;
						else state_q <= S_FETCH;
					end
				end
				S_TFETCH: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) state_q <= S_MAC;
				end
				S_MAC: begin
					k_q <= k_q + 2'd1;
					if ((k_q == 2'd3) && axis_q) state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_out.valid && div_out.axis) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				px_q    <= s_axis_tdata[IDX_W +: COORD_W];
				py_q    <= s_axis_tdata[IDX_W + COORD_W +: COORD_W];
				col_q   <= '0;
				row_q   <= '0;
				base_q  <= '0;
				tri_q   <= 1'b0;
				found_q <= 1'b0;
				mx_q    <= '0;
				my_q    <= '0;
			end
			S_FETCH: begin
				if (k_q == 2'd1) va_q <= ref_rdata;
				if (k_q == 2'd2) vb_q <= ref_rdata;
				if (k_q == 2'd3) vc_q <= ref_rdata;
			end
			S_CALC: begin
				if (k_q == 2'd0) tot_q <= f_val;
				if (k_q == 2'd1) aa_q <= f_val;
				if (k_q == 2'd2) ab_q <= f_val;
				if (k_q == 2'd3) begin
					wa_q  <= mag(aa_q);
					wb_q  <= mag(ab_q);
					wc_q  <= mag(ac);
					den_q <= mag(tot_q);
					if (!hit) begin
						tri_q <= !tri_q;
						if (tri_q) begin
							if (col_q == cols_eff - CW'(1)) begin
								col_q  <= '0;
								row_q  <= row_q + RW'(1);
								base_q <= base_q + AW'(2);
							end else begin
								col_q  <= col_q + CW'(1);
								base_q <= base_q + AW'(1);
							end
						end
					end
				end
			end
			S_TFETCH: begin
				axis_q <= 1'b0;
				if (k_q == 2'd1) ta_q <= tgt_rdata;
				if (k_q == 2'd2) tb_q <= tgt_rdata;
				if (k_q == 2'd3) tc_q <= tgt_rdata;
			end
			S_MAC: begin
				if (k_q == 2'd0) acc_q <= prod;
				else if (k_q != 2'd3) acc_q <= acc_q + prod;
				else axis_q <= 1'b1;
			end
			S_DIV: begin
				if (div_out.valid) begin
					if (div_out.axis) begin
						my_q    <= div_out.quo[QUO_W-1:FRAC_W];
						found_q <= 1'b1;
					end else begin
						mx_q <= div_out.quo[QUO_W-1:FRAC_W];
					end
				end
			end
			S_DONE: begin
				if (out_load) begin
					out_x_q     <= mx_q;
					out_y_q     <= my_q;
					out_found_q <= found_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_y_q, out_x_q};
	assign m_axis_tuser  = out_found_q;

`ifndef NO_ASSERTIONS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state register not one-hot");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_out.valid) else $error("quotient chain busy while idle");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ref_we || tgt_we) |-> (state_q == S_IDLE)) else $error("grid write during search");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("miss result not zero");
`endif
endmodule
`default_nettype wire

FILE: dv/twm_checker.sv
// Scoreboard for the mesh point warp: mirrors grids and config, predicts and checks maps.
`timescale 1ns / 100ps
module twm_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [23:0] m_axis_tdata,
	input  wire logic        m_axis_tuser,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [twm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [twm_pkg::CFG_W-1:0]     cfg_data,
	output int               fail_count,
	output int               maps_pending
);
	import twm_pkg::*;

	localparam int DEPTH = (DEF_MAX_COLS + 1) * (DEF_MAX_ROWS + 1);

	typedef struct packed {
		logic [11:0] mapped_x;
		logic [11:0] mapped_y;
		logic        found;
	} warp_out_t;

	logic [15:0] ref_x [DEPTH];
	logic [15:0] ref_y [DEPTH];
	logic [15:0] tgt_x [DEPTH];
	logic [15:0] tgt_y [DEPTH];
	logic [CFG_W-1:0] cols_reg, rows_reg;
	warp_out_t expected_maps[$];

	assign maps_pending = expected_maps.size();

	function automatic longint edge_cross(longint px, longint py, longint ax, longint ay,
			longint bx, longint by);
		return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
	endfunction

	function automatic bit same_side(longint p1x, longint p1y, longint p2x, longint p2y,
			longint ax, longint ay, longint bx, longint by);
		longint c1, c2;
		c1 = edge_cross(p1x, p1y, ax, ay, bx, by);
		c2 = edge_cross(p2x, p2y, ax, ay, bx, by);
		if (c1 == 0 || c2 == 0) return 1'b1;
		return (c1 > 0) == (c2 > 0);
	endfunction

	function automatic logic [11:0] blend(longint sa, longint sb, longint sc,
			longint aa, longint ab, longint ac, longint tot);
		longint num, q;
		num = sa * aa + sb * ab + sc * ac;
		if (tot < 0) begin
			num = -num;
			tot = -tot;
		end
		if (num <= 0) return 12'd0;
		q = (num / tot) / 16;
		if (q > 4095) q = 4095;
		return q[11:0];
	endfunction

	// returns 1 and fills res on a hit
	function automatic bit hit_triangle(longint px, longint py, int ia, int ib, int ic,
			output warp_out_t res);
		longint ax, ay, bx, by, cx, cy, tot, aa, ab, ac;
		ax = longint'(ref_x[ia]); ay = longint'(ref_y[ia]);
		bx = longint'(ref_x[ib]); by = longint'(ref_y[ib]);
		cx = longint'(ref_x[ic]); cy = longint'(ref_y[ic]);
		res = '0;
		if (!(same_side(px, py, ax, ay, bx, by, cx, cy) &&
				same_side(px, py, bx, by, ax, ay, cx, cy) &&
				same_side(px, py, cx, cy, ax, ay, bx, by)))
			return 1'b0;
		tot = (ax - bx) * (ay - cy) - (ay - by) * (ax - cx);
		if (tot == 0) return 1'b0;
		aa = (px - bx) * (py - cy) - (py - by) * (px - cx);
		ab = (ax - px) * (ay - cy) - (ay - py) * (ax - cx);
		ac = tot - aa - ab;
		res.mapped_x = blend(longint'(tgt_x[ia]), longint'(tgt_x[ib]), longint'(tgt_x[ic]),
			aa, ab, ac, tot);
		res.mapped_y = blend(longint'(tgt_y[ia]), longint'(tgt_y[ib]), longint'(tgt_y[ic]),
			aa, ab, ac, tot);
		res.found = 1'b1;
		return 1'b1;
	endfunction

	function automatic warp_out_t warp_point(longint px, longint py);
		int cols, rows, stride, tl;
		warp_out_t res;
		cols = (cols_reg == 0) ? 1 :
			(cols_reg > DEF_MAX_COLS) ? int'(DEF_MAX_COLS) : int'(cols_reg);
		rows = (rows_reg == 0) ? 1 :
			(rows_reg > DEF_MAX_ROWS) ? int'(DEF_MAX_ROWS) : int'(rows_reg);
		stride = cols + 1;
		for (int j = 0; j < rows; j++) begin
			for (int i = 0; i < cols; i++) begin
				tl = i + j * stride;
				if (hit_triangle(px, py, tl, tl + 1, tl + stride, res)) return res;
				if (hit_triangle(px, py, tl + 1, tl + stride + 1, tl + stride, res)) return res;
			end
		end
		return '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		warp_out_t got, exp_out;
		logic [6:0] idx;
		if (!arst_n) begin
			cols_reg <= 4'd4;
			rows_reg <= 4'd4;
			fail_count <= 0;
			expected_maps.delete();
			for (int k = 0; k < DEPTH; k++) begin
				ref_x[k] = '0; ref_y[k] = '0; tgt_x[k] = '0; tgt_y[k] = '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GRID_COLS) cols_reg <= cfg_data;
				else if (cfg_index == REG_GRID_ROWS) rows_reg <= cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				idx = s_axis_tdata[6:0];
				if (s_axis_tuser == CMD_LOAD_REF && idx < DEPTH) begin
					ref_x[idx] = s_axis_tdata[22:7];
					ref_y[idx] = s_axis_tdata[38:23];
				end else if (s_axis_tuser == CMD_LOAD_TGT && idx < DEPTH) begin
					tgt_x[idx] = s_axis_tdata[22:7];
					tgt_y[idx] = s_axis_tdata[38:23];
				end else if (s_axis_tuser == CMD_MAP) begin
					expected_maps.push_back(warp_point(longint'(s_axis_tdata[22:7]),
						longint'(s_axis_tdata[38:23])));
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.mapped_x = m_axis_tdata[11:0];
				got.mapped_y = m_axis_tdata[23:12];
				got.found = m_axis_tuser;
				if (expected_maps.size() == 0) begin
					$error("unexpected result transfer: x=%0d y=%0d found=%0d",
						got.mapped_x, got.mapped_y, got.found);
					fail_count <= fail_count + 1;
				end else begin
					exp_out = expected_maps.pop_front();
					if (got !== exp_out) begin
						if (got.mapped_x !== exp_out.mapped_x)
							$error("mapped_x: expected %0d, actual %0d", exp_out.mapped_x, got.mapped_x);
						if (got.mapped_y !== exp_out.mapped_y)
							$error("mapped_y: expected %0d, actual %0d", exp_out.mapped_y, got.mapped_y);
						if (got.found !== exp_out.found)
							$error("found: expected %0d, actual %0d", exp_out.found, got.found);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

FILE: dv/tb_triangle_mesh_point_warp.sv
// Testbench top for the mesh point warp: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_triangle_mesh_point_warp;
	import twm_pkg::*;

	localparam int DEPTH = (DEF_MAX_COLS + 1) * (DEF_MAX_ROWS + 1);
	localparam longint CYCLE_LIMIT = 6000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = CMD_LOAD_REF;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_COLS;
	logic [CFG_W-1:0]     cfg_data = '0;
	int          fail_count, maps_pending;
	longint      cycles = 0;

	logic [15:0] grid_px [DEPTH];
	logic [15:0] grid_py [DEPTH];
	int          act_cols, act_rows;
	int          burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	triangle_mesh_point_warp dut (.*);

	twm_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: stall style changes with bits 8:7 of the cycle counter
	always @(posedge clk) begin
		case (cycles[8:7])
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= ($urandom_range(0, 1) == 0);
			2'd2: m_axis_tready <= ($urandom_range(0, 9) == 0);
			default: m_axis_tready <= cycles[3];
		endcase
	end

	task automatic send(logic [1:0] cmd, logic [6:0] idx, logic [15:0] x, logic [15:0] y);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {1'b0, y, x, idx};
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (maps_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_grid(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
		wait_idle();
		write_reg(REG_GRID_COLS, cols);
		write_reg(REG_GRID_ROWS, rows);
		act_cols = (cols == 0) ? 1 : (cols > DEF_MAX_COLS) ? int'(DEF_MAX_COLS) : int'(cols);
		act_rows = (rows == 0) ? 1 : (rows > DEF_MAX_ROWS) ? int'(DEF_MAX_ROWS) : int'(rows);
	endtask

	// jittered lattice for the active mesh, warped targets; full also fills unused slots
	task automatic load_mesh(bit full);
		int stride, sx, sy, idx, jx, jy, tx, ty;
		stride = act_cols + 1;
		sx = 57600 / act_cols;
		sy = 57600 / act_rows;
		for (int k = 0; k < DEPTH; k++) begin
			if (k < stride * (act_rows + 1)) begin
				jx = $urandom_range(0, sx / 4) - sx / 8;
				jy = $urandom_range(0, sy / 4) - sy / 8;
				grid_px[k] = 16'(1600 + (k % stride) * sx + jx);
				grid_py[k] = 16'(1600 + (k / stride) * sy + jy);
				send(CMD_LOAD_REF, 7'(k), grid_px[k], grid_py[k]);
				tx = grid_px[k] + int'($urandom_range(0, 8000)) - 4000;
				ty = grid_py[k] + int'($urandom_range(0, 8000)) - 4000;
				if ($urandom_range(0, 9) == 0) tx = $urandom_range(0, 65535);
				send(CMD_LOAD_TGT, 7'(k), 16'(tx < 0 ? 0 : tx > 65535 ? 65535 : tx),
					16'(ty < 0 ? 0 : ty > 65535 ? 65535 : ty));
			end else if (full) begin
				send(CMD_LOAD_REF, 7'(k), 16'($urandom), 16'($urandom));
				send(CMD_LOAD_TGT, 7'(k), 16'($urandom), 16'($urandom));
			end
		end
	endtask

	task automatic random_items(int n);
		int r, k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, (act_cols + 1) * (act_rows + 1) - 1);
			if (r < 72)
				send(CMD_MAP, 7'($urandom), 16'($urandom_range(0, 62000)),
					16'($urandom_range(0, 62000)));
			else if (r < 82)
				send(CMD_MAP, 7'($urandom), 16'($urandom), 16'($urandom));
			else if (r < 88)
				send(CMD_MAP, 7'($urandom), grid_px[k], grid_py[k]);
			else if (r < 92) begin
				grid_px[k] = 16'(int'(grid_px[k]) + int'($urandom_range(0, 200)) - 100);
				send(CMD_LOAD_REF, 7'(k), grid_px[k], grid_py[k]);
			end else if (r < 95)
				send(CMD_LOAD_TGT, 7'(k), 16'($urandom), 16'($urandom));
			else if (r < 98)
				send(2'($urandom_range(0, 1)), 7'($urandom_range(DEPTH, 127)),
					16'($urandom), 16'($urandom));
			else
				send(CMD_NOP, 7'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		act_cols = 4;
		act_rows = 4;
		load_mesh(1'b1);

		// corners, vertices, misses, ignored commands
		send(CMD_MAP, 7'h7F, 16'h0000, 16'h0000);
		send(CMD_MAP, 7'h00, 16'hFFFF, 16'hFFFF);
		send(CMD_MAP, 7'h00, grid_px[0], grid_py[0]);
		send(CMD_MAP, 7'h00, grid_px[24], grid_py[24]);
		send(CMD_MAP, 7'h00, grid_px[12], grid_py[12]);
		send(CMD_MAP, 7'h00, 16'((int'(grid_px[0]) + int'(grid_px[6])) / 2),
			16'((int'(grid_py[0]) + int'(grid_py[6])) / 2));
		send(CMD_MAP, 7'h00, 16'hFFFF, 16'h0000);
		send(CMD_LOAD_REF, 7'h7F, 16'hFFFF, 16'hFFFF);
		send(CMD_LOAD_TGT, 7'd81, 16'hFFFF, 16'hFFFF);
		send(CMD_NOP, 7'h7F, 16'hFFFF, 16'hFFFF);
		send(CMD_MAP, 7'h00, grid_px[12], grid_py[12]);
		random_items(140);

		set_grid(4'd1, 4'd1);
		load_mesh(1'b0);
		random_items(120);
		// degenerate triangles: collapse all four corners onto one point
		for (int k = 0; k < 4; k++) send(CMD_LOAD_REF, 7'(k), 16'd20000, 16'd20000);
		send(CMD_MAP, 7'h00, 16'd20000, 16'd20000);
		send(CMD_MAP, 7'h00, 16'd20001, 16'd20000);
		send(CMD_LOAD_REF, 7'd1, 16'd40000, 16'd20000);
		send(CMD_MAP, 7'h00, 16'd30000, 16'd20000);
		load_mesh(1'b0);
		random_items(30);

		set_grid(4'd8, 4'd8);
		load_mesh(1'b0);
		random_items(150);

		set_grid(4'd0, 4'd15);
		load_mesh(1'b0);
		random_items(100);

		set_grid(4'd5, 4'd3);
		load_mesh(1'b0);
		random_items(100);

		wait_idle();
		repeat (1100) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/twm_pkg.sv
hw/rtl/twm_ram.sv
hw/rtl/twm_div_cell.sv
hw/rtl/twm_divider.sv
hw/rtl/triangle_mesh_point_warp.sv
dv/twm_checker.sv
dv/tb_triangle_mesh_point_warp.sv
